// ----- rtl/dcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_pkg - shared types and helpers of the day count to date decoder
// Widths, calendar constants, the sequencer state type and the small
// calendar and BCD functions that the decoder's modules share.
// ----------------------------------------------------------------------------
package dcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DAY_W  = 16;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DOM_W  = 5;
	localparam int unsigned LEN_W  = 9;
	localparam int unsigned NIB_W  = 4;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR      = 12'd1978;
	// The only multiple of 100 in the reachable span 1978..2157 that is
	// not a multiple of 400.
	localparam logic [YEAR_W-1:0] NONLEAP_CENTURY = 12'd2100;

	localparam logic [LEN_W-1:0] LEAP_YEAR_DAYS   = 9'd366;
	localparam logic [LEN_W-1:0] COMMON_YEAR_DAYS = 9'd365;

	localparam logic [MON_W-1:0] MON_JAN = 4'd0;
	localparam logic [MON_W-1:0] MON_FEB = 4'd1;
	localparam logic [MON_W-1:0] MON_DEC = 4'd11;

	typedef enum logic [1:0] {
		S_IDLE,
		S_YEAR,
		S_MONTH,
		S_DONE
	} dcd_state_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [MON_W-1:0]  month;
		logic [DOM_W-1:0]  day_of_month;
	} dcd_date_t;

	typedef struct packed {
		logic idle;
		logic done;
	} dcd_stat_t;

	// Gregorian rule, reduced to the year span that a 16-bit count reaches.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
	endfunction

	function automatic logic [DOM_W-1:0] month_len(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DOM_W-1:0] len;
		case (m)
			4'd0:    len = 5'd31;
			4'd1:    len = leap ? 5'd29 : 5'd28;
			4'd2:    len = 5'd31;
			4'd3:    len = 5'd30;
			4'd4:    len = 5'd31;
			4'd5:    len = 5'd30;
			4'd6:    len = 5'd31;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd30;
			4'd9:    len = 5'd31;
			4'd10:   len = 5'd30;
			4'd11:   len = 5'd31;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Tens nibble times ten plus units nibble; nibbles are not range checked.
	function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] b);
		logic [NIB_W-1:0] tens;
		logic [NIB_W-1:0] units;
		tens  = b[BYTE_W-1:NIB_W];
		units = b[NIB_W-1:0];
		return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, units};
	endfunction

endpackage

// ----- rtl/dcd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_req_if / dcd_rsp_if - request and response channels of the decoder
// Valid/ready channels; a word moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface dcd_req_if import dcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] day_count_low;
	logic [BYTE_W-1:0] day_count_high;
	logic [BYTE_W-1:0] hour_bcd;
	logic [BYTE_W-1:0] minute_bcd;

	modport source (
		output valid, day_count_low, day_count_high, hour_bcd, minute_bcd,
		input  ready
	);
	modport sink (
		input  valid, day_count_low, day_count_high, hour_bcd, minute_bcd,
		output ready
	);
endinterface

interface dcd_rsp_if import dcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [YEAR_W-1:0] year;
	logic [MON_W-1:0]  month;
	logic [DOM_W-1:0]  day_of_month;
	logic [BYTE_W-1:0] hour;
	logic [BYTE_W-1:0] minute;

	modport source (
		output valid, year, month, day_of_month, hour, minute,
		input  ready
	);
	modport sink (
		input  valid, year, month, day_of_month, hour, minute,
		output ready
	);
endinterface

// ----- rtl/day_count_to_date_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_date_decoder - day count and BCD time to calendar date
// Turns a 16-bit day count since 1 January 1978 into year, month and day of
// month, and packed-BCD hour and minute into binary.
// ----------------------------------------------------------------------------
// Each request word carries a day count (low and high byte) and BCD hour and
// minute; each one yields exactly one response word. Counts 0 and 1 both mean
// 1 January 1978, and 65535 is 5 June 2157. Hour and minute are tens nibble
// times ten plus units nibble with no range check, so 0xFF reads as 165. The
// date is found by a single shared subtractor that removes one whole year per
// cycle and then one whole month per cycle, from 0 to 179 whole years past
// 1978 and from 0 to 11 whole months. The longest conversion is for a date in
// December 2156, since the last reachable year ends in June. The request side
// is not ready while that subtraction runs. A finished response sits in an
// output register, so the decoder takes the next request word while the
// previous response still waits to be read.
// ----------------------------------------------------------------------------
module day_count_to_date_decoder import dcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	dcd_req_if.sink   req,
	dcd_rsp_if.source rsp
);

	dcd_stat_t         stat;
	dcd_date_t         date;
	logic              accept;
	logic              load;

	logic [BYTE_W-1:0] hour_q;
	logic [BYTE_W-1:0] minute_q;

	logic              rsp_valid_q;
	dcd_date_t         rsp_date_q;
	logic [BYTE_W-1:0] rsp_hour_q;
	logic [BYTE_W-1:0] rsp_minute_q;

	// The request side opens only when the converter is free.
	assign req.ready = stat.idle;
	assign accept    = req.valid && stat.idle;

	// A finished date moves into the output register when that is empty or
	// is being emptied in the same cycle; that move also frees the converter.
	assign load      = stat.done && (!rsp_valid_q || rsp.ready);

	dcd_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.days_in ({req.day_count_high, req.day_count_low}),
		.take    (load),
		.stat    (stat),
		.date    (date)
	);

	// Time of day is decoded on entry and held beside the running conversion.
	always_ff @(posedge clk) begin
		if (accept) begin
			hour_q   <= bcd_to_bin(req.hour_bcd);
			minute_q <= bcd_to_bin(req.minute_bcd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_date_q   <= date;
			rsp_hour_q   <= hour_q;
			rsp_minute_q <= minute_q;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.year         = rsp_date_q.year;
	assign rsp.month        = rsp_date_q.month;
	assign rsp.day_of_month = rsp_date_q.day_of_month;
	assign rsp.hour         = rsp_hour_q;
	assign rsp.minute       = rsp_minute_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!rsp_valid_q || rsp.ready))
		else $error("day_count_to_date_decoder: pending response overwritten");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("day_count_to_date_decoder: ready right after accept");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_date_q.month >= 4'd1 && rsp_date_q.month <= 4'd12))
		else $error("day_count_to_date_decoder: month out of range");
`endif

endmodule

// ----- rtl/dcd_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcd_engine - iterative day count to calendar date converter
// One shared subtractor removes one whole year, then one whole month, per
// cycle under a four-state sequencer.
// ----------------------------------------------------------------------------
module dcd_engine import dcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DAY_W-1:0] days_in,
	input  logic             take,
	output dcd_stat_t        stat,
	output dcd_date_t        date
);

	dcd_state_t        state_q;
	dcd_state_t        state_nxt;
	logic [DAY_W-1:0]  days_q;
	logic [YEAR_W-1:0] year_q;
	logic [MON_W-1:0]  mon_q;

	logic              leap;
	logic [LEN_W-1:0]  len;
	logic [DAY_W:0]    diff;
	logic              borrow;
	logic              last_mon;

	// Shared unit: one subtract whose borrow doubles as the compare.
	assign leap     = is_leap(year_q);
	assign len      = (state_q == S_YEAR)
		? (leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS)
		: {{(LEN_W-DOM_W){1'b0}}, month_len(mon_q, leap)};
	assign diff     = {1'b0, days_q} - {{(DAY_W+1-LEN_W){1'b0}}, len};
	assign borrow   = diff[DAY_W];
	assign last_mon = (mon_q >= MON_DEC);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:  if (start) state_nxt = S_YEAR;
			S_YEAR:  if (borrow) state_nxt = S_MONTH;
			S_MONTH: if (borrow || last_mon) state_nxt = S_DONE;
			S_DONE:  if (take) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					// Counts 0 and 1 both mean the epoch day.
					days_q <= (days_in == '0) ? '0 : days_in - 1'b1;
					year_q <= EPOCH_YEAR;
					mon_q  <= MON_JAN;
				end
			end
			S_YEAR: begin
				if (!borrow) begin
					days_q <= diff[DAY_W-1:0];
					year_q <= year_q + 1'b1;
				end
			end
			S_MONTH: begin
				if (!borrow && !last_mon) begin
					days_q <= diff[DAY_W-1:0];
					mon_q  <= mon_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.idle         = (state_q == S_IDLE);
		stat.done         = (state_q == S_DONE);
		date.year         = year_q;
		date.month        = mon_q + 1'b1;
		date.day_of_month = days_q[DOM_W-1:0] + 1'b1;
	end

`ifndef SYNTHESIS
	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("dcd_engine: start while busy");

	a_month_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MONTH || state_q == S_DONE) |-> mon_q <= MON_DEC)
		else $error("dcd_engine: month index out of range");

	a_result_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> (days_q < 16'd31 && year_q <= 12'd2157))
		else $error("dcd_engine: result out of range");

	a_take_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && take) |=> state_q == S_IDLE)
		else $error("dcd_engine: did not return to idle after take");

	a_year_stable_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MONTH && $past(state_q) == S_MONTH) |-> $stable(year_q))
		else $error("dcd_engine: year changed during month pass");
`endif

endmodule

// ----- bench/day_count_to_date_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_count_to_date_decoder_tb - self-checking bench for the date decoder
// Drives day counts and BCD time words into the decoder and checks every
// response word against a calendar computed in the bench.
// ----------------------------------------------------------------------------
// A short directed run covers the epoch (counts 0 and 1), month and year
// boundaries, leap days in 1980, 2000 and the non-leap 2100, the largest
// count and non-BCD nibbles. About 1400 random words follow. The run passes
// through three pacing modes: a sparse sender with a slow receiver, the
// reverse, and both sides at full rate. Twice the receiver holds off for a
// long stretch so that the decoder fills up and stalls its request side,
// and twice the sender waits until all outstanding responses have drained.
// ----------------------------------------------------------------------------
module day_count_to_date_decoder_tb;
	import dcd_pkg::*;

	// Cycles the receiver refuses responses during a forced hold-off.
	localparam int unsigned RSP_HOLD_CYCLES = 600;
	// Cycles without any accepted word before the run is declared hung.
	// The worst legal gap is the forced hold-off plus one full decode.
	localparam int unsigned STALL_LIMIT     = 4000;
	// Settling time after the last response, longer than the worst decode.
	localparam int unsigned TAIL_CYCLES     = 200;
	localparam int unsigned RANDOM_WORDS    = 1400;
	// Keeps a badly broken design from flooding the log.
	localparam int unsigned REPORT_LIMIT    = 100;

	// Pacing mode of the two sides. SLOW_SINK: sender idles 23 percent,
	// receiver 57 percent. SLOW_SOURCE: the other way round. FULL: no idling.
	typedef enum logic [1:0] {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FULL
	} pace_t;

	// One request word as queued for the driver, with its pacing controls.
	typedef struct {
		logic [BYTE_W-1:0] day_count_low;
		logic [BYTE_W-1:0] day_count_high;
		logic [BYTE_W-1:0] hour_bcd;
		logic [BYTE_W-1:0] minute_bcd;
		pace_t             pace;
		bit                wait_drain;   // hold this word until nothing is outstanding
		bit                hold_replies; // start a long receiver hold-off when sent
	} stamp_word_t;

	// The response word that a request must produce.
	typedef struct {
		dcd_date_t         date;
		logic [BYTE_W-1:0] hour;
		logic [BYTE_W-1:0] minute;
	} decoded_stamp_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dcd_req_if req_ch ();
	dcd_rsp_if rsp_ch ();

	day_count_to_date_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Month lengths of a common year; February is worked out per year.
	int unsigned month_days_tbl [12] = '{31, 0, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	stamp_word_t    pending_words[$];   // words not yet offered to the decoder
	decoded_stamp_t expected_stamps[$]; // responses owed by accepted requests
	stamp_word_t    offer;              // word currently on the request channel
	bit             req_fired     = 1'b0;
	pace_t          pace          = PACE_SLOW_SINK;
	int unsigned    hold_requests = 0;
	int unsigned    hold_served   = 0;
	int unsigned    hold_left     = 0;
	int unsigned    stall_cycles  = 0;
	int unsigned    fail_count    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Calendar prediction
	// ------------------------------------------------------------------

	// Full Gregorian rule, independent of the span the decoder can reach.
	function automatic bit gregorian_leap(input int unsigned yr);
		return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
		if (mon == 1) begin
			return gregorian_leap(yr) ? 29 : 28;
		end
		return month_days_tbl[mon];
	endfunction

	// Strips whole years and then whole months off the day count. Counts 0
	// and 1 both land on the epoch day. December is never stripped, so the
	// remainder after November is always the day within December.
	function automatic decoded_stamp_t decode_stamp(input stamp_word_t w);
		decoded_stamp_t r;
		int unsigned    days;
		int unsigned    yr;
		int unsigned    mon;
		int unsigned    span;
		days = {w.day_count_high, w.day_count_low};
		if (days != 0) begin
			days = days - 1;
		end
		yr   = EPOCH_YEAR;
		span = gregorian_leap(yr) ? 366 : 365;
		while (days >= span) begin
			days = days - span;
			yr   = yr + 1;
			span = gregorian_leap(yr) ? 366 : 365;
		end
		mon = 0;
		while (mon < 11 && days >= days_in_month(mon, yr)) begin
			days = days - days_in_month(mon, yr);
			mon  = mon + 1;
		end
		r.date.year         = YEAR_W'(yr);
		r.date.month        = MON_W'(mon + 1);
		r.date.day_of_month = DOM_W'(days + 1);
		// Nibbles are taken as they are, so 0xFF gives 15 * 10 + 15.
		r.hour   = BYTE_W'(w.hour_bcd[7:4] * 10 + w.hour_bcd[3:0]);
		r.minute = BYTE_W'(w.minute_bcd[7:4] * 10 + w.minute_bcd[3:0]);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int unsigned gap_pct(input pace_t p, input bit sender);
		case (p)
			PACE_SLOW_SINK:   return sender ? 23 : 57;
			PACE_SLOW_SOURCE: return sender ? 57 : 23;
			default:          return 0;
		endcase
	endfunction

	// Mostly well-formed BCD in 0..top, sometimes an arbitrary byte so that
	// the nibbles above nine are exercised as well.
	function automatic logic [BYTE_W-1:0] pick_bcd(input int unsigned top);
		int unsigned v;
		if ($urandom_range(0, 9) < 3) begin
			return BYTE_W'($urandom_range(0, 255));
		end
		v = $urandom_range(0, top);
		return {NIB_W'(v / 10), NIB_W'(v % 10)};
	endfunction

	task automatic queue_word(input int unsigned count, input logic [BYTE_W-1:0] hb,
		input logic [BYTE_W-1:0] mb, input pace_t p, input bit drain, input bit hold);
		stamp_word_t w;
		w.day_count_low  = count[7:0];
		w.day_count_high = count[15:8];
		w.hour_bcd       = hb;
		w.minute_bcd     = mb;
		w.pace           = p;
		w.wait_drain     = drain;
		w.hold_replies   = hold;
		pending_words.push_back(w);
	endtask

	task automatic report_field(input string field, input int unsigned want,
		input int unsigned got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: changes the channel only at the falling edge. A word
	// stays on the channel until the monitor has seen it accepted.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : request_driver
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_fired) begin
			req_fired = 1'b0;
			if (pending_words.size() != 0
				&& !(pending_words[0].wait_drain && expected_stamps.size() != 0)
				&& $urandom_range(0, 99) >= gap_pct(pending_words[0].pace, 1'b1)) begin
				offer = pending_words.pop_front();
				req_ch.day_count_low  <= offer.day_count_low;
				req_ch.day_count_high <= offer.day_count_high;
				req_ch.hour_bcd       <= offer.hour_bcd;
				req_ch.minute_bcd     <= offer.minute_bcd;
				req_ch.valid          <= 1'b1;
				pace                  <= offer.pace;
				if (offer.hold_replies) begin
					hold_requests <= hold_requests + 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response sink: random back-pressure per pacing mode, plus the long
	// hold-offs that the driver asks for. The hold-off is counted here.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : response_sink
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_served + 1;
			hold_left   = RSP_HOLD_CYCLES - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= gap_pct(pace, 1'b0));
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge. A response word is
	// checked before a request accepted at the same edge is predicted, so a
	// response can never be matched against its own request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : word_monitor
		logic           moved;
		decoded_stamp_t want;
		moved = 1'b0;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			moved = 1'b1;
			if (expected_stamps.size() == 0) begin
				fail_count++;
				$display("%0t ns: response word with no request outstanding, actual %0d-%0d-%0d %0d:%0d",
					$time, rsp_ch.year, rsp_ch.month, rsp_ch.day_of_month,
					rsp_ch.hour, rsp_ch.minute);
			end else begin
				want = expected_stamps.pop_front();
				if (rsp_ch.year !== want.date.year)
					report_field("year", want.date.year, rsp_ch.year);
				if (rsp_ch.month !== want.date.month)
					report_field("month", want.date.month, rsp_ch.month);
				if (rsp_ch.day_of_month !== want.date.day_of_month)
					report_field("day_of_month", want.date.day_of_month, rsp_ch.day_of_month);
				if (rsp_ch.hour !== want.hour)
					report_field("hour", want.hour, rsp_ch.hour);
				if (rsp_ch.minute !== want.minute)
					report_field("minute", want.minute, rsp_ch.minute);
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			moved = 1'b1;
			expected_stamps.push_back(decode_stamp(offer));
			req_fired = 1'b1;
		end
		stall_cycles = moved ? 0 : stall_cycles + 1;
	end

	// A hung decoder or handshake ends the run here.
	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL day_count_to_date_decoder");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// ------------------------------------------------------------------
	initial begin : stimulus
		// Epoch, month ends, the first day of 1979, 29 February 1980,
		// 31 December 1980, 29 February 2000, 28 February and 1 March 2100,
		// one byte set at a time, and the largest counts.
		int unsigned       corner_counts [20] = '{0, 1, 2, 31, 32, 59, 60, 365, 366, 730,
			731, 790, 1096, 8095, 44619, 44620, 255, 65280, 65534, 65535};
		logic [BYTE_W-1:0] corner_bcd [9] = '{8'h00, 8'hFF, 8'h59, 8'h23, 8'hA5,
			8'h5A, 8'h99, 8'h0F, 8'hF0};
		int unsigned       count;
		int unsigned       sel;
		pace_t             p;

		req_ch.valid          = 1'b0;
		req_ch.day_count_low  = '0;
		req_ch.day_count_high = '0;
		req_ch.hour_bcd       = '0;
		req_ch.minute_bcd     = '0;
		rsp_ch.ready          = 1'b0;

		for (int i = 0; i < 20; i++) begin
			queue_word(corner_counts[i], corner_bcd[i % 9], corner_bcd[(i + 4) % 9],
				PACE_SLOW_SINK, 1'b0, 1'b0);
		end

		// Random part: full-range counts, early years that decode quickly,
		// and the far end of the range where the year loop runs longest.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				count = $urandom_range(0, 65535);
			end else if (sel < 8) begin
				count = $urandom_range(0, 4000);
			end else begin
				count = $urandom_range(60000, 65535);
			end
			p = (i < 480) ? PACE_SLOW_SINK : (i < 960) ? PACE_SLOW_SOURCE : PACE_FULL;
			// Drain before each new pacing mode; long receiver hold-offs once
			// in the first mode and once at full rate.
			queue_word(count, pick_bcd(23), pick_bcd(59), p, (i == 480) || (i == 960),
				(i == 200) || (i == 1100));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || req_ch.valid || expected_stamps.size() != 0)
			@(negedge clk);
		// Any stray response word in this window is flagged by the monitor.
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("PASS day_count_to_date_decoder");
		end else begin
			$display("FAIL day_count_to_date_decoder");
		end
		$finish;
	end

endmodule
